FILE: rtl/adeq_pkg.sv
// ----------------------------------------------------------------------------
// adeq_pkg
// Shared widths, command and status codes for the array double-ended queue.
// ----------------------------------------------------------------------------
package adeq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned STAT_W    = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_REAR  = 3'd1,
    CMD_DEL_FRONT = 3'd2,
    CMD_DEL_REAR  = 3'd3,
    CMD_LIST      = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE          = 3'd0,
    STAT_FRONT_BLOCKED = 3'd1,
    STAT_REAR_FULL     = 3'd2,
    STAT_EMPTY         = 3'd3,
    STAT_LISTED        = 3'd4
  } status_e;

endpackage

FILE: rtl/array_double_ended_queue.sv
// ----------------------------------------------------------------------------
// array_double_ended_queue
// Double-ended queue held in a linear array with front and rear indices.
// ----------------------------------------------------------------------------
// Usage: commands enter on the slave stream (tuser carries the command, tdata
// the value to insert); results leave on the master stream (tuser carries the
// status, tdata the deleted or listed item, tlast marks the final result of a
// command). Every command except an unknown code yields at least one result.
// Inserts, refusals and empty answers appear in the cycle after acceptance,
// and a new item is taken every cycle while the output register is free. A
// delete reads the entry store, whose read port is registered, so its result
// passes through the read data register and then the output register, and the
// block takes no new item until that result is loaded. A listing makes one
// read per item through the same memory port, overlapped with the output of
// the previous item. Reset sets both indices to minus one
// (empty, never used) and empties the output register; the entry store is
// not cleared, so no clearing pass is needed. When the receiver stalls, the
// result stays in the output register and the block holds: it takes no new
// item and issues no further list read until the output register frees up.
// ----------------------------------------------------------------------------
module array_double_ended_queue #(
  parameter int unsigned DEPTH = adeq_pkg::DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // slave stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [adeq_pkg::DATA_W-1:0]  s_axis_tdata,  // [31:0] value
  input  logic [adeq_pkg::CMD_W-1:0]   s_axis_tuser,  // [2:0] command
  // master stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [adeq_pkg::DATA_W-1:0]  m_axis_tdata,  // [31:0] item
  output logic [adeq_pkg::STAT_W-1:0]  m_axis_tuser,  // [2:0] status
  output logic                         m_axis_tlast
);

  import adeq_pkg::*;

  // Address width and signed index width (index spans minus one to DEPTH)
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IW = $clog2(DEPTH + 1) + 1;

  localparam logic signed [IW-1:0] MINUS_ONE = '1;
  localparam logic signed [IW-1:0] IDX_ZERO  = '0;
  localparam logic signed [IW-1:0] IDX_ONE   = IW'(1);
  localparam logic signed [IW-1:0] TOP_IDX   = IW'(DEPTH - 1);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // take commands
  localparam logic [1:0] ST_DEL  = 2'd1;  // deleted item arriving from memory
  localparam logic [1:0] ST_LIST = 2'd2;  // stream entries front to rear

  logic [1:0] state_q, state_d;

  logic signed [IW-1:0] front_q, front_d;
  logic signed [IW-1:0] rear_q, rear_d;
  logic [AW-1:0]        ptr_q, ptr_d;

  // Output register
  logic              out_valid_q;
  logic [DATA_W-1:0] out_item_q;
  logic [STAT_W-1:0] out_stat_q;
  logic              out_last_q;

  logic              out_load;
  logic [DATA_W-1:0] out_item;
  status_e           out_stat;
  logic              out_last;
  logic              out_free;

  // Memory port
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  logic                 accept;
  logic                 empty_front;
  logic                 empty_rear;
  logic                 empty_list;
  logic                 list_end;
  logic signed [IW-1:0] front_dec;
  logic signed [IW-1:0] front_inc;
  logic signed [IW-1:0] rear_inc;
  logic signed [IW-1:0] rear_dec;

  adeq_mem #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (s_axis_tdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The output slot is free when empty or being taken this cycle
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign front_dec = front_q - IDX_ONE;
  assign front_inc = front_q + IDX_ONE;
  assign rear_inc  = rear_q + IDX_ONE;
  assign rear_dec  = rear_q - IDX_ONE;

  // Empty tests, signed compares on the indices
  assign empty_front = (front_q == MINUS_ONE) || (front_q > rear_q);
  assign empty_rear  = (rear_q == MINUS_ONE) || (front_q > rear_q);
  assign empty_list  = (rear_q == MINUS_ONE) || (front_q < IDX_ZERO) || (front_q > rear_q);
  assign list_end    = (ptr_q == rear_q[AW-1:0]);

  always_comb begin
    state_d   = state_q;
    front_d   = front_q;
    rear_d    = rear_q;
    ptr_d     = ptr_q;
    out_load  = 1'b0;
    out_item  = '0;
    out_stat  = STAT_DONE;
    out_last  = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            CMD_INS_FRONT: begin
              out_load = 1'b1;
              if (front_q == IDX_ZERO) begin
                out_stat = STAT_FRONT_BLOCKED;
              end else if (front_q == MINUS_ONE) begin
                // First use: both ends land on entry zero
                front_d   = IDX_ZERO;
                rear_d    = IDX_ZERO;
                mem_we    = 1'b1;
                mem_waddr = '0;
              end else begin
                front_d   = front_dec;
                mem_we    = 1'b1;
                mem_waddr = front_dec[AW-1:0];
              end
            end
            CMD_INS_REAR: begin
              out_load = 1'b1;
              if (rear_q >= TOP_IDX) begin
                out_stat = STAT_REAR_FULL;
              end else begin
                rear_d    = rear_inc;
                mem_we    = 1'b1;
                mem_waddr = rear_inc[AW-1:0];
                if (front_q == MINUS_ONE) begin
                  front_d = IDX_ZERO;
                end
              end
            end
            CMD_DEL_FRONT: begin
              if (empty_front) begin
                out_load = 1'b1;
                out_stat = STAT_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = front_q[AW-1:0];
                front_d   = front_inc;
                state_d   = ST_DEL;
              end
            end
            CMD_DEL_REAR: begin
              if (empty_rear) begin
                out_load = 1'b1;
                out_stat = STAT_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = rear_q[AW-1:0];
                rear_d    = rear_dec;
                state_d   = ST_DEL;
              end
            end
            CMD_LIST: begin
              if (empty_list) begin
                out_load = 1'b1;
                out_stat = STAT_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = front_q[AW-1:0];
                ptr_d     = front_q[AW-1:0];
                state_d   = ST_LIST;
              end
            end
            default: begin
              // Unknown command: drop without a result
            end
          endcase
        end
      end
      ST_DEL: begin
        if (out_free) begin
          out_load = 1'b1;
          out_item = mem_rdata;
          state_d  = ST_IDLE;
        end
      end
      ST_LIST: begin
        // Load the current entry and fetch the next one in the same cycle
        if (out_free) begin
          out_load = 1'b1;
          out_stat = STAT_LISTED;
          out_item = mem_rdata;
          out_last = list_end;
          if (list_end) begin
            state_d = ST_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = ptr_q + AW'(1);
            ptr_d     = ptr_q + AW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= MINUS_ONE;
      rear_q      <= MINUS_ONE;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      rear_q  <= rear_d;
      ptr_q   <= ptr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload, advanced only when a new result is loaded
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q <= out_item;
      out_stat_q <= out_stat;
      out_last_q <= out_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_item_q;
  assign m_axis_tuser  = out_stat_q;
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: rtl/adeq_mem.sv
// ----------------------------------------------------------------------------
// adeq_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module adeq_mem #(
  parameter int unsigned DEPTH  = adeq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_W = adeq_pkg::DATA_W,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the array double-ended queue. A short table of
// commands walks the empty, blocked, full and emptied-region corners, then a
// long run of random commands grows and shrinks the queue in epochs. Every
// accepted command is run through a behavioural model of the queue here, and
// each result on the master stream is checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import adeq_pkg::*;

  localparam int unsigned QDEPTH = DEPTH_DEF;

  // Command codes the block ignores: no result, no state change.
  localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 375;
  localparam int unsigned QUIET_TAIL   = 80;   // final items run without idling

  typedef struct packed {
    status_e             status;
    logic [DATA_W-1:0]   item;
    logic                last;
  } result_t;

  // One row of the directed table. Rows with has_typed carry a hand-written
  // single result; all others take whatever the queue model produces.
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [DATA_W-1:0]   value;
    int                  reps;
    bit                  has_typed;
    status_e             status;
    logic [DATA_W-1:0]   item;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [DATA_W-1:0]   s_axis_tdata;   // [31:0] value
  logic [CMD_W-1:0]    s_axis_tuser;   // [2:0] command
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [DATA_W-1:0]   m_axis_tdata;   // [31:0] item
  logic [STAT_W-1:0]   m_axis_tuser;   // [2:0] status
  logic                m_axis_tlast;

  // Queue model state: entry store and signed front/rear indices.
  logic [DATA_W-1:0]   deque_store [QDEPTH];
  int                  front_idx;
  int                  rear_idx;

  result_t             step_results [$];   // results of the latest command
  result_t             pending_results [$]; // results still owed by the block
  int                  error_count;
  bit                  idle_en;
  int                  out_stall_left;
  row_t                directed_rows [25];

  array_double_ended_queue #(
    .DEPTH (QDEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: far beyond the slowest correct run (every item listing sixteen
  // entries, each result held up by the longest receiver stall).
  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic result_t make_result(status_e st, logic [DATA_W-1:0] d, logic lst);
    result_t r;
    r.status = st;
    r.item   = d;
    r.last   = lst;
    return r;
  endfunction

  // Apply one command to the queue model and collect the results it causes.
  function automatic void run_deque_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value);
    int i;
    step_results.delete();
    case (cmd)
      CMD_INS_FRONT: begin
        if (front_idx == 0) begin
          step_results.push_back(make_result(STAT_FRONT_BLOCKED, '0, 1'b1));
        end else begin
          // A never-used queue starts both indices at entry zero.
          if (front_idx == -1) begin
            front_idx = 0;
            rear_idx  = 0;
          end else begin
            front_idx--;
          end
          deque_store[front_idx] = value;
          step_results.push_back(make_result(STAT_DONE, '0, 1'b1));
        end
      end
      CMD_INS_REAR: begin
        if (rear_idx >= int'(QDEPTH) - 1) begin
          step_results.push_back(make_result(STAT_REAR_FULL, '0, 1'b1));
        end else begin
          rear_idx++;
          deque_store[rear_idx] = value;
          if (front_idx == -1) front_idx = 0;
          step_results.push_back(make_result(STAT_DONE, '0, 1'b1));
        end
      end
      CMD_DEL_FRONT: begin
        if (front_idx == -1 || front_idx > rear_idx) begin
          step_results.push_back(make_result(STAT_EMPTY, '0, 1'b1));
        end else begin
          step_results.push_back(make_result(STAT_DONE, deque_store[front_idx], 1'b1));
          front_idx++;
        end
      end
      CMD_DEL_REAR: begin
        if (rear_idx == -1 || front_idx > rear_idx) begin
          step_results.push_back(make_result(STAT_EMPTY, '0, 1'b1));
        end else begin
          step_results.push_back(make_result(STAT_DONE, deque_store[rear_idx], 1'b1));
          rear_idx--;
        end
      end
      CMD_LIST: begin
        if (rear_idx == -1 || front_idx < 0 || front_idx > rear_idx) begin
          step_results.push_back(make_result(STAT_EMPTY, '0, 1'b1));
        end else begin
          for (i = front_idx; i <= rear_idx; i++)
            step_results.push_back(make_result(STAT_LISTED, deque_store[i], i == rear_idx));
        end
      end
      default: ; // reserved codes: drop silently
    endcase
  endfunction

  function automatic void note_mismatch(string msg);
    error_count++;
    if (error_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endfunction

  // Present one item on the slave stream, hold it until accepted, then book
  // its results. Entered and left just after a falling edge.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value, bit has_typed,
                              status_e st, logic [DATA_W-1:0] itm);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = value;
    s_axis_tuser  = cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    run_deque_command(cmd, value);
    if (has_typed) begin
      pending_results.push_back(make_result(st, itm, 1'b1));
    end else begin
      foreach (step_results[k]) pending_results.push_back(step_results[k]);
    end
    @(negedge clk_i);
  endtask

  // Receiver: hold off in random bursts while idling is enabled.
  initial begin
    m_axis_tready  = 1'b0;
    out_stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (out_stall_left > 0) begin
        m_axis_tready = 1'b0;
        out_stall_left--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready  = 1'b0;
        out_stall_left = $urandom_range(0, 4);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Checker: compare each accepted result with the oldest one owed.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result status %0d item %h last %b",
                                m_axis_tuser, m_axis_tdata, m_axis_tlast));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status)
          note_mismatch($sformatf("status expected %0d got %0d", want.status, m_axis_tuser));
        if (m_axis_tdata !== want.item)
          note_mismatch($sformatf("item expected %h got %h", want.item, m_axis_tdata));
        if (m_axis_tlast !== want.last)
          note_mismatch($sformatf("last expected %b got %b", want.last, m_axis_tlast));
      end
    end
  end

  initial begin
    int            accepted;
    int            pick;
    bit            grow;
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] value;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    front_idx     = -1;
    rear_idx      = -1;
    error_count   = 0;
    idle_en       = 1'b1;

    // Directed corners: empty after reset, never-used inserts, front blocked,
    // emptied region refilled from the front, rear full and a full listing.
    directed_rows = '{
      '{CMD_LIST,      32'h0000_0000,  1, 1'b1, STAT_EMPTY,         32'h0000_0000},
      '{CMD_DEL_FRONT, 32'h0000_0000,  1, 1'b1, STAT_EMPTY,         32'h0000_0000},
      '{CMD_DEL_REAR,  32'h0000_0000,  1, 1'b1, STAT_EMPTY,         32'h0000_0000},
      '{CMD_RSVD5,     32'hFFFF_FFFF,  1, 1'b0, STAT_DONE,          32'h0000_0000},
      '{CMD_INS_FRONT, 32'h8000_0000,  1, 1'b1, STAT_DONE,          32'h0000_0000},
      '{CMD_INS_FRONT, 32'h0000_0001,  1, 1'b1, STAT_FRONT_BLOCKED, 32'h0000_0000},
      '{CMD_INS_REAR,  32'h7FFF_FFFF,  1, 1'b1, STAT_DONE,          32'h0000_0000},
      '{CMD_INS_REAR,  32'hFFFF_FFFF,  1, 1'b1, STAT_DONE,          32'h0000_0000},
      '{CMD_LIST,      32'h0000_0000,  1, 1'b0, STAT_DONE,          32'h0000_0000},
      '{CMD_DEL_FRONT, 32'h0000_0000,  1, 1'b1, STAT_DONE,          32'h8000_0000},
      '{CMD_INS_FRONT, 32'h0000_0000,  1, 1'b1, STAT_DONE,          32'h0000_0000},
      '{CMD_DEL_REAR,  32'h0000_0000,  1, 1'b1, STAT_DONE,          32'hFFFF_FFFF},
      '{CMD_DEL_FRONT, 32'h0000_0000,  1, 1'b0, STAT_DONE,          32'h0000_0000},
      '{CMD_DEL_FRONT, 32'h0000_0000,  1, 1'b0, STAT_DONE,          32'h0000_0000},
      '{CMD_DEL_REAR,  32'h0000_0000,  1, 1'b1, STAT_EMPTY,         32'h0000_0000},
      '{CMD_LIST,      32'h0000_0000,  1, 1'b1, STAT_EMPTY,         32'h0000_0000},
      '{CMD_INS_FRONT, 32'hA5A5_A5A5,  1, 1'b1, STAT_DONE,          32'h0000_0000},
      '{CMD_RSVD7,     32'h5A5A_5A5A,  1, 1'b0, STAT_DONE,          32'h0000_0000},
      '{CMD_LIST,      32'h0000_0000,  1, 1'b0, STAT_DONE,          32'h0000_0000},
      '{CMD_INS_REAR,  32'h1357_9BDF, 14, 1'b0, STAT_DONE,          32'h0000_0000},
      '{CMD_INS_REAR,  32'h2468_ACE0,  1, 1'b1, STAT_REAR_FULL,     32'h0000_0000},
      '{CMD_INS_FRONT, 32'h0F0F_0F0F,  1, 1'b1, STAT_DONE,          32'h0000_0000},
      '{CMD_LIST,      32'h0000_0000,  1, 1'b0, STAT_DONE,          32'h0000_0000},
      '{CMD_DEL_REAR,  32'h0000_0000,  1, 1'b0, STAT_DONE,          32'h0000_0000},
      '{CMD_RSVD6,     32'hC3C3_3C3C,  1, 1'b0, STAT_DONE,          32'h0000_0000}
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[r]) begin
      for (int n = 0; n < directed_rows[r].reps; n++)
        send_command(directed_rows[r].cmd, directed_rows[r].value + n,
                     directed_rows[r].has_typed, directed_rows[r].status,
                     directed_rows[r].item);
    end

    // Random part: pick growing or shrinking epochs at random so the queue swings
    // between empty and full. Reserved codes are sprinkled in but not counted.
    accepted = 0;
    grow     = 1'b1;
    while (accepted < RANDOM_ITEMS) begin
      if (accepted % 32 == 0) grow = 1'($urandom_range(0, 1));
      if (accepted >= RANDOM_ITEMS - QUIET_TAIL) idle_en = 1'b0;
      pick  = $urandom_range(0, 99);
      value = $urandom();
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       value = 32'h0000_0000;
          1:       value = 32'h8000_0000;
          2:       value = 32'h7FFF_FFFF;
          default: value = 32'hFFFF_FFFF;
        endcase
      end
      if (pick < 4)                   cmd = CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
      else if (pick < 14)             cmd = CMD_LIST;
      else if (grow && pick < 60)     cmd = CMD_INS_REAR;
      else if (grow && pick < 76)     cmd = CMD_INS_FRONT;
      else if (grow && pick < 88)     cmd = CMD_DEL_FRONT;
      else if (grow)                  cmd = CMD_DEL_REAR;
      else if (pick < 28)             cmd = CMD_INS_REAR;
      else if (pick < 38)             cmd = CMD_INS_FRONT;
      else if (pick < 70)             cmd = CMD_DEL_FRONT;
      else                            cmd = CMD_DEL_REAR;
      send_command(cmd, value, 1'b0, STAT_DONE, '0);
      if (cmd <= CMD_LIST) accepted++;
    end
    s_axis_tvalid = 1'b0;

    // Drain: wait for every owed result, then keep watching for strays.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/adeq_pkg.sv
rtl/adeq_mem.sv
rtl/array_double_ended_queue.sv
sim/testbench.sv
